[hw/rtl/xrg_pkg.sv]
package xrg_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned NumerW = 54;
  localparam int unsigned HalfW  = 32;

  localparam logic [WordW-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

  localparam logic CMD_NEXT = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH,
    MUL_END
  } mul_phase_e;

  typedef struct packed {
    logic       load_seed;
    logic       round_start;
    logic       mul_en;
    mul_phase_e mul_phase;
    logic       mul_b;
    logic [1:0] word_idx;
    logic       advance;
  } xrg_ctl_t;

endpackage

[hw/rtl/xrg_if.sv]
interface xrg_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

interface xrg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;
  logic [53:0] uniform_numerator;

  modport source (output valid, output random_word, output uniform_numerator, input ready);
  modport sink (input valid, input random_word, input uniform_numerator, output ready);
endinterface

[hw/rtl/xrg_datapath.sv]
module xrg_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrg_pkg::xrg_ctl_t ctl_i,
  input  logic [63:0]       seed_i,
  output logic [63:0]       word_o,
  output logic [53:0]       numer_o
);
  import xrg_pkg::*;

  logic [WordW-1:0] run_q, run_d;
  logic [WordW-1:0] z_q, prod_q, acc_q, word_q;
  logic [WordW-1:0] st_q [4];

  logic [WordW-1:0] mul_k, mul_p, mac_sum, round_sum, mix_a, mix_b;
  logic [HalfW-1:0] mul_x, mul_y;
  logic [WordW-1:0] sum03, rot23, word_d, t17, s3x;

  // shared 32x32 multiplier, one partial product per cycle
  always_comb begin
    mul_k = ctl_i.mul_b ? MIX_MUL_B : MIX_MUL_A;
    mul_x = (ctl_i.mul_phase == MUL_HL) ? z_q[WordW-1:HalfW] : z_q[HalfW-1:0];
    mul_y = (ctl_i.mul_phase == MUL_LH) ? mul_k[WordW-1:HalfW] : mul_k[HalfW-1:0];
    mul_p = {{HalfW{1'b0}}, mul_x} * {{HalfW{1'b0}}, mul_y};
    mac_sum = acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
    mix_a = mac_sum ^ (mac_sum >> 27);
    mix_b = mac_sum ^ (mac_sum >> 31);
    round_sum = run_q + GOLDEN_INC;
  end

  // xoshiro256++ output and advance
  always_comb begin
    sum03  = st_q[0] + st_q[3];
    rot23  = {sum03[40:0], sum03[63:41]};
    word_d = rot23 + st_q[0];
    t17    = st_q[1] << 17;
    s3x    = st_q[3] ^ st_q[1];
  end

  always_comb begin
    run_d = run_q;
    if (ctl_i.load_seed) begin
      run_d = seed_i;
    end else if (ctl_i.round_start) begin
      run_d = round_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.round_start) begin
      z_q <= round_sum ^ (round_sum >> 30);
    end
    if (ctl_i.mul_en) begin
      case (ctl_i.mul_phase)
        MUL_LL: begin
          prod_q <= mul_p;
        end
        MUL_HL: begin
          acc_q  <= prod_q;
          prod_q <= mul_p;
        end
        MUL_LH: begin
          acc_q  <= mac_sum;
          prod_q <= mul_p;
        end
        MUL_END: begin
          if (!ctl_i.mul_b) begin
            z_q <= mix_a;
          end
        end
        default: begin
          prod_q <= prod_q;
        end
      endcase
    end
    if (ctl_i.mul_en && ctl_i.mul_b && (ctl_i.mul_phase == MUL_END)) begin
      st_q[ctl_i.word_idx] <= mix_b;
    end else if (ctl_i.advance) begin
      st_q[0] <= st_q[0] ^ st_q[3] ^ st_q[1];
      st_q[1] <= st_q[1] ^ st_q[2] ^ st_q[0];
      st_q[2] <= st_q[2] ^ st_q[0] ^ t17;
      st_q[3] <= {s3x[18:0], s3x[63:19]};
    end
    if (ctl_i.advance) begin
      word_q <= word_d;
    end
  end

  assign word_o  = word_q;
  assign numer_o = {1'b0, word_q[WordW-1:11]} + NumerW'(1);

endmodule

[hw/rtl/xrg_controller.sv]
module xrg_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xrg_pkg::xrg_ctl_t ctl_o
);
  import xrg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_MA0,
    S_MA1,
    S_MA2,
    S_MA3,
    S_MB0,
    S_MB1,
    S_MB2,
    S_MB3
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] round_q, round_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o             = '0;
    ctl_o.word_idx    = round_q;
    ctl_o.load_seed   = in_acc && (in_cmd_i == CMD_SEED);
    ctl_o.advance     = in_acc && (in_cmd_i == CMD_NEXT);
    ctl_o.round_start = (state_q == S_ROUND);
    ctl_o.mul_phase   = MUL_LL;
    case (state_q)
      S_MA0: begin ctl_o.mul_en = 1'b1; ctl_o.mul_phase = MUL_LL; end
      S_MA1: begin ctl_o.mul_en = 1'b1; ctl_o.mul_phase = MUL_HL; end
      S_MA2: begin ctl_o.mul_en = 1'b1; ctl_o.mul_phase = MUL_LH; end
      S_MA3: begin ctl_o.mul_en = 1'b1; ctl_o.mul_phase = MUL_END; end
      S_MB0: begin ctl_o.mul_en = 1'b1; ctl_o.mul_b = 1'b1; ctl_o.mul_phase = MUL_LL; end
      S_MB1: begin ctl_o.mul_en = 1'b1; ctl_o.mul_b = 1'b1; ctl_o.mul_phase = MUL_HL; end
      S_MB2: begin ctl_o.mul_en = 1'b1; ctl_o.mul_b = 1'b1; ctl_o.mul_phase = MUL_LH; end
      S_MB3: begin ctl_o.mul_en = 1'b1; ctl_o.mul_b = 1'b1; ctl_o.mul_phase = MUL_END; end
      default: begin
        ctl_o.mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd_i == CMD_SEED) begin
            state_d = S_ROUND;
            round_d = '0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_ROUND: state_d = S_MA0;
      S_MA0:   state_d = S_MA1;
      S_MA1:   state_d = S_MA2;
      S_MA2:   state_d = S_MA3;
      S_MA3:   state_d = S_MB0;
      S_MB0:   state_d = S_MB1;
      S_MB1:   state_d = S_MB2;
      S_MB2:   state_d = S_MB3;
      S_MB3: begin
        round_d = round_q + 2'd1;
        state_d = (round_q == 2'd3) ? S_IDLE : S_ROUND;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset runs the seed-zero expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ROUND;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_seed_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd_i == CMD_SEED)) |=> (state_q == S_ROUND) && (round_q == 2'd0))
    else $error("reseed did not start expansion");

  a_seed_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MB3) && (round_q == 2'd3) |=> (state_q == S_IDLE))
    else $error("expansion did not end after four rounds");

  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd_i == CMD_NEXT)) |=> out_valid_q)
    else $error("next word not presented");

  a_busy_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ctl_o.advance && !in_ready_o)
    else $error("word accepted during expansion");

endmodule

[hw/rtl/xoshiro256pp_random_generator.sv]
// channel | dir | handshake        | word
// in_i    | in  | valid / ready    | cmd, seed_value
// res_o   | out | valid / ready    | random_word, uniform_numerator
//
// next word: one per cycle while res_o is taken, result registered and presented in the cycle after acceptance
// reseed: busy after acceptance, four splitmix64 rounds on one shared 32x32 multiplier
// reset: the seed-zero expansion runs first, with input ready low
// stalls: the result register holds while res_o is not taken; in_i ready drops until it is
module xoshiro256pp_random_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  xrg_in_if.sink    in_i,
  xrg_out_if.source res_o
);
  import xrg_pkg::*;

  xrg_ctl_t ctl;

  xrg_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .ctl_o       (ctl)
  );

  xrg_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .seed_i  (in_i.seed_value),
    .word_o  (res_o.random_word),
    .numer_o (res_o.uniform_numerator)
  );

endmodule
